// File: rtl/core/bcaf_pkg.sv
package bcaf_pkg;

   // Button positions in the debounced level word.
   localparam int unsigned NUM_BUTTONS = 5;
   localparam int unsigned NUM_FIRE    = 3;
   localparam int unsigned BTN_SPEED   = 3;
   localparam int unsigned BTN_AXIS    = 4;

   // Field widths.
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned INTERVAL_W = 20;
   localparam int unsigned SPEED_W    = 4;
   localparam int unsigned BLINK_W    = 5;
   localparam int unsigned CSR_IDX_W  = 3;

   // Number of speed steps; the index wraps after the last one.
   localparam int unsigned SPEED_LEVELS = 4;
   localparam logic [SPEED_W-1:0] SPEED_LAST = SPEED_W'(SPEED_LEVELS - 1);
   localparam logic [SPEED_W:0]   SPEED_LIMIT = (SPEED_W + 1)'(SPEED_LEVELS);

   // Combo flag bit positions.
   localparam int unsigned CF_SPD_ACTIVE = 0;
   localparam int unsigned CF_SPD_USED   = 1;
   localparam int unsigned CF_MS_ACTIVE  = 2;
   localparam int unsigned CF_MS_ARMED   = 3;

   // Register map of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_INTERVAL = 3'd0,
      CSR_AUTOFIRE_INTERVAL = 3'd1,
      CSR_GAMEPAD_MODE      = 3'd2,
      CSR_START_SPEED       = 3'd3,
      CSR_START_AUTOFIRE    = 3'd4
   } csr_index_type;

   // Debouncer status for the current sample.
   typedef struct packed {
      logic [NUM_BUTTONS-1:0] levels;
      logic [NUM_BUTTONS-1:0] accepted;
   } deb_status_type;

   // Live configuration seen by the combo logic.
   typedef struct packed {
      logic [INTERVAL_W-1:0] autofire_interval_us;
      logic                  gamepad_mode;
   } combo_cfg_type;

   // One result item.
   typedef struct packed {
      logic [NUM_BUTTONS-1:0] report_buttons;
      logic                   axis_select;
      logic [SPEED_W-1:0]     speed_setting;
      logic [NUM_FIRE-1:0]    autofire_enables;
      logic                   save_request;
      logic                   mode_switch_request;
      logic [BLINK_W-1:0]     blink_count;
      logic                   activity_pulse;
   } result_type;

endpackage

// File: rtl/core/bcaf_debounce.sv
module bcaf_debounce import bcaf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [TIME_W-1:0]      now_us,
   input  logic [NUM_BUTTONS-1:0] raw_levels,
   input  logic [INTERVAL_W-1:0]  debounce_interval_us,
   output deb_status_type         status
);

   logic [NUM_BUTTONS-1:0] levels_ff;
   logic [NUM_BUTTONS-1:0] levels_in;
   logic [NUM_BUTTONS-1:0] accepted;
   logic [TIME_W-1:0]      change_time_ff [NUM_BUTTONS];
   logic [TIME_W-1:0]      change_time_in [NUM_BUTTONS];
   logic [TIME_W-1:0]      change_eff     [NUM_BUTTONS];
   logic [TIME_W-1:0]      change_due     [NUM_BUTTONS];

   // Per-button lockout: a change time in the future counts as zero, and a raw
   // change is taken once the lockout since the last taken change has run out.
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         change_eff[i] = (change_time_ff[i] > now_us) ? '0 : change_time_ff[i];
         change_due[i] = change_eff[i] + TIME_W'(debounce_interval_us);
         accepted[i]   = (raw_levels[i] != levels_ff[i]) && (change_due[i] <= now_us);
         levels_in[i]  = accepted[i] ? raw_levels[i] : levels_ff[i];
         change_time_in[i] = accepted[i] ? now_us : change_eff[i];
      end
   end

   assign status.levels   = levels_in;
   assign status.accepted = accepted;

   // Debouncer state advances with each transferred sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= '0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            change_time_ff[i] <= '0;
         end
      end else if (step) begin
         levels_ff <= levels_in;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            change_time_ff[i] <= change_time_in[i];
         end
      end
   end

endmodule

// File: rtl/core/bcaf_combo.sv
module bcaf_combo import bcaf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [TIME_W-1:0]    now_us,
   input  deb_status_type       status,
   input  combo_cfg_type        cfg,
   input  logic                 load_speed,
   input  logic                 load_autofire,
   input  logic [SPEED_W-1:0]   load_value,
   output result_type           result
);

   logic [3:0]          combo_ff;
   logic [3:0]          combo_in;
   logic [SPEED_W-1:0]  speed_ff;
   logic [SPEED_W-1:0]  speed_in;
   logic                axis_ff;
   logic                axis_in;
   logic [NUM_FIRE-1:0] enables_ff;
   logic [NUM_FIRE-1:0] enables_in;
   logic [NUM_FIRE-1:0] phase_ff;
   logic [NUM_FIRE-1:0] phase_in;
   logic [TIME_W-1:0]   toggle_time_ff [NUM_FIRE];
   logic [TIME_W-1:0]   toggle_time_in [NUM_FIRE];
   logic [TIME_W-1:0]   since_toggle   [NUM_FIRE];

   logic                   mouse;
   logic                   spd;
   logic                   axs;
   logic [NUM_FIRE-1:0]    fire_lv;
   logic [NUM_FIRE-1:0]    fire_out;
   logic [NUM_FIRE-1:0]    fire_en;
   logic [NUM_FIRE-1:0]    final_bits;
   logic                   save;
   logic                   msreq;
   logic                   act;
   logic [BLINK_W-1:0]     blink;
   logic [SPEED_W-1:0]     preset_speed;

   assign mouse   = ~cfg.gamepad_mode;
   assign spd     = status.levels[BTN_SPEED];
   assign axs     = status.levels[BTN_AXIS];
   assign fire_lv = status.levels[NUM_FIRE-1:0];

   // An out-of-range preset speed loads as the first step.
   assign preset_speed = ({1'b0, load_value} < SPEED_LIMIT) ? load_value : '0;

   // Speed release, axis toggle, mode-switch and speed+fire combos.
   always_comb begin
      combo_in   = combo_ff;
      speed_in   = speed_ff;
      axis_in    = axis_ff;
      enables_in = enables_ff;
      save       = 1'b0;
      msreq      = 1'b0;
      blink      = '0;

      if (status.accepted[BTN_SPEED] && !spd) begin
         if (!combo_ff[CF_SPD_USED] && !combo_ff[CF_MS_ACTIVE]) begin
            if (mouse) begin
               speed_in = (speed_ff == SPEED_LAST) ? '0 : speed_ff + 1'b1;
               blink    = {1'b0, speed_in} + 1'b1;
            end
            save = 1'b1;
         end
         combo_in[CF_SPD_ACTIVE] = 1'b0;
         combo_in[CF_SPD_USED]   = 1'b0;
      end

      if (status.accepted[BTN_AXIS] && axs && !spd) begin
         axis_in = ~axis_ff;
      end

      if (!spd || !axs) begin
         combo_in[CF_MS_ACTIVE] = 1'b0;
         combo_in[CF_MS_ARMED]  = 1'b1;
      end
      if (combo_in[CF_MS_ARMED] && spd && axs && !combo_in[CF_MS_ACTIVE]) begin
         combo_in[CF_MS_ACTIVE] = 1'b1;
         combo_in[CF_SPD_USED]  = 1'b1;
         combo_in[CF_MS_ARMED]  = 1'b0;
         msreq = 1'b1;
      end

      // Only the lowest pressed fire button has its autofire toggled.
      if (mouse && !combo_in[CF_MS_ACTIVE] && !combo_in[CF_SPD_ACTIVE] && spd &&
          (fire_lv != '0)) begin
         combo_in[CF_SPD_ACTIVE] = 1'b1;
         combo_in[CF_SPD_USED]   = 1'b1;
         save = 1'b1;
         if (fire_lv[0]) begin
            enables_in[0] = ~enables_ff[0];
         end else if (fire_lv[1]) begin
            enables_in[1] = ~enables_ff[1];
         end else begin
            enables_in[2] = ~enables_ff[2];
         end
      end
   end

   // Fire buttons are masked while a speed combo is held.
   assign fire_out = combo_in[CF_SPD_ACTIVE] ? '0 : fire_lv;
   assign fire_en  = mouse ? enables_in : '0;

   // Autofire oscillators, one per fire button.
   always_comb begin
      act = 1'b0;
      for (int i = 0; i < NUM_FIRE; i++) begin
         since_toggle[i]   = now_us - toggle_time_ff[i];
         phase_in[i]       = phase_ff[i];
         toggle_time_in[i] = toggle_time_ff[i];
         if (fire_en[i] && fire_out[i]) begin
            if (since_toggle[i] >= TIME_W'(cfg.autofire_interval_us)) begin
               phase_in[i]       = ~phase_ff[i];
               toggle_time_in[i] = now_us;
               if (!phase_ff[i]) begin
                  act = 1'b1;
               end
            end
         end else begin
            toggle_time_in[i] = now_us;
            phase_in[i]       = 1'b0;
         end
         final_bits[i] = fire_en[i] ? phase_in[i] : fire_out[i];
      end
   end

   assign result.report_buttons      = {axs, spd, final_bits};
   assign result.axis_select         = axis_in;
   assign result.speed_setting       = speed_in;
   assign result.autofire_enables    = enables_in;
   assign result.save_request        = save;
   assign result.mode_switch_request = msreq;
   assign result.blink_count         = blink;
   assign result.activity_pulse      = act;

   // State registers; preset writes load directly and win over a sample step.
   always_ff @(posedge clock) begin
      if (reset) begin
         combo_ff   <= '0;
         speed_ff   <= '0;
         axis_ff    <= 1'b0;
         enables_ff <= '0;
         phase_ff   <= '0;
         for (int i = 0; i < NUM_FIRE; i++) begin
            toggle_time_ff[i] <= '0;
         end
      end else begin
         if (load_speed) begin
            speed_ff <= preset_speed;
         end else if (step) begin
            speed_ff <= speed_in;
         end
         if (load_autofire) begin
            enables_ff <= load_value[NUM_FIRE-1:0];
         end else if (step) begin
            enables_ff <= enables_in;
         end
         if (step) begin
            combo_ff <= combo_in;
            axis_ff  <= axis_in;
            phase_ff <= phase_in;
            for (int i = 0; i < NUM_FIRE; i++) begin
               toggle_time_ff[i] <= toggle_time_in[i];
            end
         end
      end
   end

endmodule

// File: rtl/core/button_debounce_combo_autofire.sv
// Five-button debouncer with speed/axis combos and autofire.
//
// Input channel (req_): one sample per transfer, a 32-bit microsecond
// timestamp and five raw button levels. Result channel (rsp_): one result
// per sample with the report button word, the axis, speed and autofire
// settings, and the save, mode-switch, blink and activity requests.
// A transfer happens when valid is high and stall is low.
//
// A sample's result is registered: it is shown in the output register in
// the cycle after the transfer. Throughput is one sample per cycle while
// the receiver does not stall; the whole step is one pass of compare and
// toggle logic between the button state and the output register.
//
// When the receiver stalls, the result holds in the output register and
// req_stall rises, so no further sample is taken until it drains.
// Reset clears the output valid flag, the debouncers and the combo state and
// restores the register defaults. Writes on the csr_ port take effect at the
// next edge; the two preset registers also load the speed index and the
// autofire enables directly.
module button_debounce_combo_autofire import bcaf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_now_us,
   input  logic                   req_fire1_level,
   input  logic                   req_fire2_level,
   input  logic                   req_fire3_level,
   input  logic                   req_speed_level,
   input  logic                   req_axis_level,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_BUTTONS-1:0] rsp_report_buttons,
   output logic                   rsp_axis_select,
   output logic [SPEED_W-1:0]     rsp_speed_setting,
   output logic [NUM_FIRE-1:0]    rsp_autofire_enables,
   output logic                   rsp_save_request,
   output logic                   rsp_mode_switch_request,
   output logic [BLINK_W-1:0]     rsp_blink_count,
   output logic                   rsp_activity_pulse,

   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [INTERVAL_W-1:0]  csr_wdata
);

   logic [INTERVAL_W-1:0] debounce_interval_ff;
   logic [INTERVAL_W-1:0] autofire_interval_ff;
   logic                  gamepad_mode_ff;
   logic                  load_speed;
   logic                  load_autofire;
   logic                  step;
   logic                  rsp_valid_ff;
   result_type            result;
   result_type            result_ff;
   deb_status_type        status;
   combo_cfg_type         combo_cfg;

   // The output register frees up when it is empty or being drained.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign step      = req_valid & ~req_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_interval_ff <= INTERVAL_W'(10000);
         autofire_interval_ff <= INTERVAL_W'(50000);
         gamepad_mode_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_INTERVAL: debounce_interval_ff <= csr_wdata;
            CSR_AUTOFIRE_INTERVAL: autofire_interval_ff <= csr_wdata;
            CSR_GAMEPAD_MODE:      gamepad_mode_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign load_speed    = csr_we && (csr_index == CSR_START_SPEED);
   assign load_autofire = csr_we && (csr_index == CSR_START_AUTOFIRE);

   assign combo_cfg.autofire_interval_us = autofire_interval_ff;
   assign combo_cfg.gamepad_mode         = gamepad_mode_ff;

   bcaf_debounce u_debounce (
      .clock                (clock),
      .reset                (reset),
      .step                 (step),
      .now_us               (req_now_us),
      .raw_levels           ({req_axis_level, req_speed_level, req_fire3_level,
                              req_fire2_level, req_fire1_level}),
      .debounce_interval_us (debounce_interval_ff),
      .status               (status)
   );

   bcaf_combo u_combo (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .now_us        (req_now_us),
      .status        (status),
      .cfg           (combo_cfg),
      .load_speed    (load_speed),
      .load_autofire (load_autofire),
      .load_value    (csr_wdata[SPEED_W-1:0]),
      .result        (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_report_buttons      = result_ff.report_buttons;
   assign rsp_axis_select         = result_ff.axis_select;
   assign rsp_speed_setting       = result_ff.speed_setting;
   assign rsp_autofire_enables    = result_ff.autofire_enables;
   assign rsp_save_request        = result_ff.save_request;
   assign rsp_mode_switch_request = result_ff.mode_switch_request;
   assign rsp_blink_count         = result_ff.blink_count;
   assign rsp_activity_pulse      = result_ff.activity_pulse;

endmodule

// File: rtl/core/bcaf_checker.sv
module bcaf_checker import bcaf_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [NUM_BUTTONS-1:0] rsp_report_buttons,
   input logic [SPEED_W-1:0]     rsp_speed_setting,
   input logic                   rsp_save_request,
   input logic [BLINK_W-1:0]     rsp_blink_count
);

   // A stalled result stays offered with the same button word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_report_buttons))
      else $error("stalled result dropped or changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A transferred sample always shows a result at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("transferred sample produced no result");

   // A blink request names the new speed step and comes with a save request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blink_count != '0) |->
         rsp_save_request && (rsp_blink_count == {1'b0, rsp_speed_setting} + 1'b1))
      else $error("blink count inconsistent with speed setting");

   // The speed step stays within the configured number of steps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_speed_setting} < SPEED_LIMIT))
      else $error("speed setting out of range");

endmodule

bind button_debounce_combo_autofire bcaf_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_report_buttons (rsp_report_buttons),
   .rsp_speed_setting  (rsp_speed_setting),
   .rsp_save_request   (rsp_save_request),
   .rsp_blink_count    (rsp_blink_count)
);
